@@ design/sha1_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 digest engine.
// Used by sha1_ctrl, sha1_dp and the top level sha1_message_digest.
package sha1_pkg;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD
  } st_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef struct packed {
    logic       shift_en;
    bsel_t      bsel;
    logic [2:0] len_idx;
    logic       start_block;
    logic       round_en;
    logic [6:0] round_idx;
    logic       fold;
    logic       emit;
  } dp_cmd_t;

  function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) k = K0;
    else if (rnd < 7'd40) k = K1;
    else if (rnd < 7'd60) k = K2;
    else k = K3;
    return k;
  endfunction

  function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

@@ design/sha1_ctrl.sv @@
// Controller state machine of the SHA-1 engine: byte position, padding
// sequence, round counter and output handshake. Depends on sha1_pkg.
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tuser,
  input  logic    in_tlast,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  output dp_cmd_t cmd
);

  st_t        state_r, state_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic       first_r, first_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       pad_pend_r, pad_pend_nxt;
  logic       final_r, final_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       len_here;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  // Whether the length field lands in the block being padded now.
  assign len_here   = first_r ? (pos_r < LEN_POS) : len_ok_r;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser && pos_r == LAST_POS) state_nxt = ST_COMP;
          else if (in_tlast) state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos_r == LAST_POS) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (rnd_r == LAST_ROUND) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (final_r) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (pad_pend_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.bsel     = BSEL_IN;
    pos_nxt      = pos_r;
    rnd_nxt      = rnd_r;
    first_nxt    = first_r;
    len_ok_nxt   = len_ok_r;
    pad_pend_nxt = pad_pend_r;
    final_nxt    = final_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          first_nxt = in_tlast;
          if (in_tuser) begin
            cmd.shift_en = 1'b1;
            pos_nxt      = pos_r + 6'd1;
            if (pos_r == LAST_POS) begin
              cmd.start_block = 1'b1;
              rnd_nxt         = '0;
              pad_pend_nxt    = in_tlast;
              final_nxt       = 1'b0;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.shift_en = 1'b1;
        cmd.len_idx  = pos_r[2:0];
        if (first_r) cmd.bsel = BSEL_PAD;
        else if (len_ok_r && pos_r >= LEN_POS) cmd.bsel = BSEL_LEN;
        else cmd.bsel = BSEL_ZERO;
        pos_nxt    = pos_r + 6'd1;
        first_nxt  = 1'b0;
        len_ok_nxt = len_here;
        if (pos_r == LAST_POS) begin
          cmd.start_block = 1'b1;
          rnd_nxt         = '0;
          final_nxt       = len_here;
          pad_pend_nxt    = !len_here;
          len_ok_nxt      = 1'b1;
        end
      end
      ST_COMP: begin
        cmd.round_en  = 1'b1;
        cmd.round_idx = rnd_r;
        rnd_nxt       = rnd_r + 7'd1;
      end
      ST_FOLD: begin
        if (final_r) begin
          if (out_free) begin
            cmd.emit  = 1'b1;
            final_nxt = 1'b0;
          end
        end else begin
          cmd.fold     = 1'b1;
          pad_pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      rnd_r       <= '0;
      first_r     <= 1'b0;
      len_ok_r    <= 1'b0;
      pad_pend_r  <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      first_r     <= first_nxt;
      len_ok_r    <= len_ok_nxt;
      pad_pend_r  <= pad_pend_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/sha1_dp.sv @@
// Datapath of the SHA-1 engine: 16-word message window, round registers,
// chaining words, byte counter and digest register. Depends on sha1_pkg.
module sha1_dp
  import sha1_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd,
  input  logic [7:0]     in_byte,
  output logic [159:0]   digest
);

  logic [31:0]  w_r [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  h_r [5];
  logic [31:0]  sum [5];
  logic [60:0]  cnt_r;
  logic [159:0] digest_r;
  logic [63:0]  len_bits;
  logic [7:0]   len_byte;
  logic [7:0]   sh_byte;
  logic [31:0]  w_new;
  logic [31:0]  t_val;
  logic [31:0]  pre;

  assign len_bits = {cnt_r, 3'b000};
  assign len_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];

  always_comb begin
    case (cmd.bsel)
      BSEL_IN:   sh_byte = in_byte;
      BSEL_PAD:  sh_byte = PAD_BYTE;
      BSEL_ZERO: sh_byte = 8'h00;
      BSEL_LEN:  sh_byte = len_byte;
      default:   sh_byte = 8'h00;
    endcase
  end

  assign pre   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {pre[30:0], pre[31]};
  assign t_val = {a_r[26:0], a_r[31:27]} + sha1_f(cmd.round_idx, b_r, c_r, d_r)
               + e_r + sha1_k(cmd.round_idx) + w_r[0];

  assign sum[0] = h_r[0] + a_r;
  assign sum[1] = h_r[1] + b_r;
  assign sum[2] = h_r[2] + c_r;
  assign sum[3] = h_r[3] + d_r;
  assign sum[4] = h_r[4] + e_r;

  // Message window: bytes shift in big-endian; rounds shift out one word.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], sh_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= IV0;
      h_r[1] <= IV1;
      h_r[2] <= IV2;
      h_r[3] <= IV3;
      h_r[4] <= IV4;
      cnt_r  <= '0;
    end else if (cmd.emit) begin
      h_r[0] <= IV0;
      h_r[1] <= IV1;
      h_r[2] <= IV2;
      h_r[3] <= IV3;
      h_r[4] <= IV4;
      cnt_r  <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 5; i++) h_r[i] <= sum[i];
      end
      if (cmd.shift_en && cmd.bsel == BSEL_IN) cnt_r <= cnt_r + 61'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) digest_r <= {sum[4], sum[3], sum[2], sum[1], sum[0]};
  end

  assign digest = digest_r;

endmodule

@@ design/sha1_message_digest.sv @@
// SHA-1 digest engine, one message byte per word; reset (rst_n low, synchronous) loads the
// initial vector and clears length and control. Byte words are taken one per cycle while
// idle; a word that fills a block starts 80 rounds plus one chaining add, taking no input.
// After the end, padding shifts one byte per cycle; the digest follows that block's rounds,
// if any, the padding and rounds of the open block, and a second such block when the length
// spills over. The final step also waits while an earlier digest is still untaken.
module sha1_message_digest
  import sha1_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] byte_present
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // [31:0] digest_word0 ... [159:128] digest_word4
);

  dp_cmd_t cmd;

  // The controller sequences byte loading, padding and rounds; it accepts words only
  // while idle, but a finished digest can wait in the output register while the next
  // message streams in. A new digest is held back until the previous one is taken.
  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // The datapath holds the message window, the round registers and the chaining words.
  sha1_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_tdata),
    .digest  (out_tdata)
  );

  // A new digest never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("digest overwritten before it was taken");

  // A loaded digest is presented on the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("digest not presented after emit");

  // No input is taken while the rounds run.
  a_no_input_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> !in_tready)
    else $error("input accepted during compression");

  // The window never loads a byte and runs a round at once.
  a_window_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift_en && cmd.round_en))
    else $error("window shift and round in the same cycle");

endmodule

@@ bench/sha1_digest_checker.sv @@
// Digest checker for sha1_message_digest: watches both stream channels,
// predicts each SHA-1 digest from the accepted words and compares it field by field.
// Depends on sha1_pkg for the initial vector, round constants and padding positions.
module sha1_digest_checker
  import sha1_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [159:0] out_tdata,
  output int           errors,
  output int           pending
);

  logic [31:0]  hash_words [5];
  logic [7:0]   block_bytes [64];
  logic [5:0]   fill_pos;
  logic [63:0]  msg_bits;
  logic [159:0] digests_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_message();
    hash_words[0] = IV0;
    hash_words[1] = IV1;
    hash_words[2] = IV2;
    hash_words[3] = IV3;
    hash_words[4] = IV4;
    fill_pos = '0;
    msg_bits = '0;
  endfunction

  // One 80-round compression of the 64 stored bytes into the hash words.
  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  // Applies one accepted input word; a word that ends the message queues its digest.
  function automatic void absorb_word(input logic present, input logic [7:0] data,
                                      input logic last);
    int p;
    logic [159:0] done_digest;
    if (present) begin
      block_bytes[fill_pos] = data;
      msg_bits += 64'd8;
      fill_pos += 6'd1;
      if (fill_pos == 6'd0) fold_block();
    end
    if (!last) return;
    p = fill_pos;
    block_bytes[p] = PAD_BYTE;
    p++;
    // The pad byte leaves no room for the length: zero out and fold an extra block.
    if (p > LEN_POS) begin
      while (p < 64) begin
        block_bytes[p] = 8'h00;
        p++;
      end
      fold_block();
      p = 0;
    end
    while (p < LEN_POS) begin
      block_bytes[p] = 8'h00;
      p++;
    end
    for (int i = 0; i < 8; i++)
      block_bytes[LEN_POS + i] = msg_bits[8*(7-i) +: 8];
    fold_block();
    done_digest = {hash_words[4], hash_words[3], hash_words[2],
                   hash_words[1], hash_words[0]};
    digests_due = {digests_due, done_digest};
    restart_message();
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [159:0] want;
    if (!rst_n) begin
      restart_message();
      digests_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        absorb_word(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (digests_due.size() == 0) begin
          flag_error($sformatf("digest %h with none outstanding", out_tdata));
        end else begin
          want = digests_due.pop_front();
          for (int i = 0; i < 5; i++)
            if (out_tdata[32*i +: 32] !== want[32*i +: 32])
              flag_error($sformatf("digest_word%0d: expected %h, got %h",
                                   i, want[32*i +: 32], out_tdata[32*i +: 32]));
        end
      end
    end
    pending <= digests_due.size();
  end

endmodule

@@ bench/sha1_message_digest_tb.sv @@
// Top of the sha1_message_digest testbench: clock, reset, word stimulus and verdict.
// Depends on sha1_message_digest, sha1_pkg and sha1_digest_checker.
module sha1_message_digest_tb;

  // Generous cycle ceiling: the slowest legal run (long gaps on every word,
  // long stalls on every digest, two-block padding) stays well below it.
  localparam int CYCLE_LIMIT = 5_000_000;
  // Quiet time after the last digest, a little over the two-block pad latency.
  localparam int DRAIN_CYCLES = 320;
  localparam int TARGET_WORDS = 1850;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;

  int errors;
  int pending;
  int cycles = 0;

  // Set while a message is sent with no idling on either side.
  bit steady = 1'b0;

  int words_sent = 0;

  sha1_message_digest u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sha1_digest_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all while steady.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  // The receiver stalls at random so that held digests are exercised.
  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sha1_message_digest_tb: done, errors");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it, then idles a while.
  // The valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic push_word(input logic present, input logic [7:0] data, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= present;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a message of random bytes. The end either rides on the final byte or
  // comes as a separate word without a byte. Ignored words are sprinkled in.
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      push_word(1'b1, 8'($urandom_range(0, 255)), end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0)
      push_word(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Lengths near the padding boundaries (pad fits, length spills, full blocks)
  // are favored; the rest are spread from zero to 80 bytes.
  function automatic int pick_length();
    int edges [13] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 12)];
    return $urandom_range(0, 80);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the empty message, a short text message with the end on its
    // last byte, a word with neither flag, an end without a byte after a zero byte
    // (its data must be ignored), an all-ones byte message, a flagless word, 80h 7Fh.
    push_word(1'b0, 8'hC3, 1'b1);
    push_word(1'b1, 8'h61, 1'b0);
    push_word(1'b1, 8'h62, 1'b0);
    push_word(1'b1, 8'h63, 1'b1);
    push_word(1'b0, 8'hA5, 1'b0);
    push_word(1'b1, 8'h00, 1'b0);
    push_word(1'b0, 8'hFF, 1'b1);
    push_word(1'b1, 8'hFF, 1'b1);
    push_word(1'b0, 8'h5A, 1'b0);
    push_word(1'b1, 8'h80, 1'b0);
    push_word(1'b1, 8'h7F, 1'b1);

    // Random messages until enough words have gone through.
    while (words_sent < TARGET_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      send_message(pick_length(), 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // The outstanding count is registered, so step once before reading it.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("sha1_message_digest_tb: done, clean");
    end else begin
      $display("sha1_message_digest_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sha1_pkg.sv
design/sha1_ctrl.sv
design/sha1_dp.sv
design/sha1_message_digest.sv
bench/sha1_digest_checker.sv
bench/sha1_message_digest_tb.sv
